@@ design/cellular_automaton_cell_update_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the cell update block
// Implication checks on the rising clock, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef CELLULAR_AUTOMATON_CELL_UPDATE_ASSERT_SVH
`define CELLULAR_AUTOMATON_CELL_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define CACU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CACU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/cacu_pkg.sv @@
// ----------------------------------------------------------------------------
// cacu_pkg
// Types and fixed constants shared by the cell update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cacu_pkg;

    localparam int CELL_W   = 16;
    localparam int FLOW_W   = 10;
    localparam int CARRY_W  = 3;
    localparam int NCELLS   = 9;
    localparam int CENTER_IX = 4;
    // 8 x 16-bit signed + flow + carry fits comfortably in 20 bits
    localparam int SUM_W    = 20;
    // eco rule only looks at the low 9 bits of each cell
    localparam int ECO_W    = 9;
    localparam int ECO_OUT_W = 10;
    localparam int CNT_W    = 4;

    localparam logic [ECO_OUT_W-1:0] HIST_MASK = 10'h3fc;
    localparam logic [CNT_W-1:0]     ONES_HI   = 4'd5;
    localparam logic [CNT_W-1:0]     ONES_EQ   = 4'd4;
    localparam logic [CNT_W-1:0]     TWOS_BIRTH = 4'd2;
    localparam logic [CNT_W-1:0]     TWOS_FIVE  = 4'd5;
    localparam logic [CNT_W-1:0]     TWOS_SIX   = 4'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_RULE_SELECT  = 2'd0;
    localparam logic [1:0] CFG_FLOW_OFFSET  = 2'd1;
    localparam logic [1:0] CFG_FLAG_PATTERN = 2'd2;

    // rule codes
    localparam logic RULE_HEAT = 1'b0;
    localparam logic RULE_ECO  = 1'b1;

    localparam logic [FLOW_W-1:0] FLOW_RESET = 10'h3f9;   // -7
    localparam logic [CELL_W-1:0] FLAG_RESET = 16'd14336;

    typedef logic signed [CELL_W-1:0] t_cell;
    typedef logic [ECO_W-1:0]         t_eco_bits;
    typedef logic [ECO_OUT_W-1:0]     t_eco_cell;

endpackage

`default_nettype wire

@@ design/cacu_eco.sv @@
// ----------------------------------------------------------------------------
// cacu_eco
// Eco rule cell kernel: brian's-brain / anti-life update on flow-shifted cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cacu_eco
    import cacu_pkg::*;
(
    input  wire t_eco_bits i_cells [NCELLS],
    input  wire t_eco_bits i_flow,
    output t_eco_cell      o_cell
);

    t_eco_bits          v [NCELLS];
    logic [CNT_W-1:0]   ones;
    logic [CNT_W-1:0]   twos;
    t_eco_bits          c;
    logic               bit1;

    always_comb begin
        ones = '0;
        twos = '0;
        for (int i = 0; i < NCELLS; i++) begin
            v[i] = i_cells[i] - i_flow;
            ones = ones + CNT_W'(v[i][0]);
            if (i != CENTER_IX) begin
                twos = twos + CNT_W'(v[i][1]);
            end
        end
        c = v[CENTER_IX];

        if (ones > ONES_HI || ones == ONES_EQ) begin
            bit1   = (c[2:1] == 2'b00) && (twos == TWOS_BIRTH);
            o_cell = ({c, 1'b0} & HIST_MASK) | {8'd0, bit1, 1'b1};
        end else begin
            if (c[1]) begin
                bit1 = (twos != TWOS_FIVE);
            end else begin
                bit1 = (twos != TWOS_FIVE) && (twos != TWOS_SIX);
            end
            o_cell = ({c ^ 9'd2, 1'b0} & HIST_MASK) | {8'd0, bit1, 1'b0};
        end
    end

endmodule

`default_nettype wire

@@ design/cellular_automaton_cell_update.sv @@
// ----------------------------------------------------------------------------
// cellular_automaton_cell_update
// One 3x3 neighborhood in, one updated center cell out (heat or eco rule).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: nine 16-bit cells with i_valid / o_stall; an item is taken
//   on a clock edge with i_valid high and o_stall low. Windows must arrive in
//   scan order, since the heat rule carries 3 bits of rounding error from
//   one item to the next.
//   Output channel: o_new_cell with o_valid / i_stall.
//   Pipeline: an accepted item passes the input register, then the result
//   register, where o_valid rises; a receiver stall can hold it in between.
//   Throughput: 1 item per cycle while the receiver does not stall; the only
//   loop is the 3-bit carry add in the compute stage.
//   When the receiver stalls, the result register holds and the input
//   register keeps taking one more item; o_stall rises only when both are
//   full.
//   Configuration: write through i_cfg_we / i_cfg_index / i_cfg_data while
//   no item is in flight. Index 3 is ignored.
//   Reset (synchronous, active low): pipeline empty, carry cleared, rule =
//   heat, flow offset = -7, flag pattern = 0x3800.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cellular_automaton_cell_update
    import cacu_pkg::*;
#(
    parameter int VALUE_BITS = 10
) (
    input  wire         i_clk,
    input  wire         i_rst_n,

    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [15:0] i_cfg_data,

    input  wire         i_valid,
    output logic        o_stall,
    input  wire t_cell  i_north_west,
    input  wire t_cell  i_north,
    input  wire t_cell  i_north_east,
    input  wire t_cell  i_west,
    input  wire t_cell  i_center,
    input  wire t_cell  i_east,
    input  wire t_cell  i_south_west,
    input  wire t_cell  i_south,
    input  wire t_cell  i_south_east,

    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_new_cell
);

    // configuration
    logic              r_rule;
    logic [FLOW_W-1:0] r_flow;
    logic [CELL_W-1:0] r_flag;

    // pipeline
    logic               r_s1_valid;
    t_cell              r_cells [NCELLS];
    logic               r_out_valid;
    logic [CELL_W-1:0]  r_new_cell;
    logic [CARRY_W-1:0] r_carry;

    logic               out_ready;
    logic               s1_move;
    logic               in_accept;

    logic [SUM_W-1:0]   heat_sum;
    logic [CELL_W-1:0]  heat_val;
    t_eco_bits          eco_low [NCELLS];
    t_eco_cell          eco_cell;
    logic [CELL_W-1:0]  eco_sum;
    logic [CELL_W-1:0]  eco_val;
    logic [CELL_W-1:0]  n_new_cell;
    logic [CARRY_W-1:0] n_carry;

    assign out_ready = !r_out_valid || !i_stall;
    assign s1_move   = r_s1_valid && out_ready;
    assign o_stall   = r_s1_valid && !out_ready;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= RULE_HEAT;
            r_flow <= FLOW_RESET;
            r_flag <= FLAG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RULE_SELECT:  r_rule <= i_cfg_data[0];
                CFG_FLOW_OFFSET:  r_flow <= i_cfg_data[FLOW_W-1:0];
                CFG_FLAG_PATTERN: r_flag <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // heat: carry + eight neighbors + flow
    always_comb begin
        heat_sum = SUM_W'(r_carry) + SUM_W'($signed(r_flow));
        for (int i = 0; i < NCELLS; i++) begin
            if (i != CENTER_IX) begin
                heat_sum = heat_sum + SUM_W'(r_cells[i]);
            end
        end
        heat_val = {{(CELL_W-VALUE_BITS){1'b0}}, heat_sum[CARRY_W +: VALUE_BITS]};
    end

    always_comb begin
        for (int i = 0; i < NCELLS; i++) begin
            eco_low[i] = r_cells[i][ECO_W-1:0];
        end
    end

    cacu_eco u_eco (
        .i_cells (eco_low),
        .i_flow  (r_flow[ECO_W-1:0]),
        .o_cell  (eco_cell)
    );

    assign eco_sum = CELL_W'($signed(r_flow)) + CELL_W'(eco_cell);
    assign eco_val = {{(CELL_W-VALUE_BITS){1'b0}}, eco_sum[VALUE_BITS-1:0]};

    always_comb begin
        if (r_rule == RULE_ECO) begin
            n_new_cell = eco_val | r_flag;
            n_carry    = r_carry;
        end else begin
            n_new_cell = heat_val | r_flag;
            n_carry    = heat_sum[CARRY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_carry     <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_carry     <= n_carry;
            end else if (out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cells[0] <= i_north_west;
            r_cells[1] <= i_north;
            r_cells[2] <= i_north_east;
            r_cells[3] <= i_west;
            r_cells[4] <= i_center;
            r_cells[5] <= i_east;
            r_cells[6] <= i_south_west;
            r_cells[7] <= i_south;
            r_cells[8] <= i_south_east;
        end
        if (s1_move) begin
            r_new_cell <= n_new_cell;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_new_cell = r_new_cell;

    `include "cellular_automaton_cell_update_assert.svh"

    `CACU_ASSERT_NEXT(a_eco_keeps_carry, i_clk, i_rst_n, s1_move && r_rule == RULE_ECO, $stable(r_carry), "eco item changed the heat carry")
    `CACU_ASSERT_IMPL(a_stall_only_when_full, i_clk, i_rst_n, o_stall, r_s1_valid && r_out_valid && i_stall, "input stalled with room in the pipeline")
    `CACU_ASSERT_NEXT(a_result_not_dropped, i_clk, i_rst_n, r_out_valid && i_stall, r_out_valid, "stalled result dropped")
    `CACU_ASSERT_NEXT(a_item_reaches_output, i_clk, i_rst_n, s1_move, r_out_valid, "item lost between stages")

endmodule

`default_nettype wire

@@ tb/cellular_automaton_cell_update_checker.sv @@
// ----------------------------------------------------------------------------
// cellular_automaton_cell_update_checker
// Watches the config port and both item channels of the cell update block,
// predicts every new cell from its own copy of the rule, flow, flags and
// heat carry, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cellular_automaton_cell_update_checker
    import cacu_pkg::*;
#(
    parameter int VALUE_BITS = 10
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    input  wire                              i_cfg_we,
    input  wire  [1:0]                       i_cfg_index,
    input  wire  [15:0]                      i_cfg_data,

    input  wire                              i_in_valid,
    input  wire                              i_in_stall,
    input  wire  [0:NCELLS-1][CELL_W-1:0]    i_window,

    input  wire                              i_out_valid,
    input  wire                              i_out_stall,
    input  wire  [CELL_W-1:0]                i_new_cell,

    output int                               o_fail_count,
    output int                               o_pending
);

    localparam logic [31:0] VALUE_MASK = (32'd1 << VALUE_BITS) - 32'd1;

    typedef logic [0:NCELLS-1][CELL_W-1:0] t_window;

    logic                 rule_q;
    logic [FLOW_W-1:0]    flow_q;
    logic [CELL_W-1:0]    flag_q;
    logic [CARRY_W-1:0]   carry_q;

    logic [CELL_W-1:0]    expected_cells[$];
    logic [CARRY_W+CELL_W-1:0] predicted;
    logic [CELL_W-1:0]    wanted;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // returns {next carry, new cell}
    function automatic logic [CARRY_W+CELL_W-1:0] predict_cell(
        input t_window            win,
        input logic [CARRY_W-1:0] carry
    );
        logic [31:0]          flow32;
        logic [31:0]          heat_sum;
        logic [31:0]          val;
        logic [CELL_W-1:0]    v;
        logic [CELL_W-1:0]    c;
        logic [CELL_W-1:0]    hist;
        logic [CARRY_W-1:0]   carry_next;
        int                   ones;
        int                   twos;
        flow32     = {{(32-FLOW_W){flow_q[FLOW_W-1]}}, flow_q};
        carry_next = carry;
        if (rule_q == RULE_HEAT) begin
            heat_sum = {29'd0, carry} + flow32;
            for (int i = 0; i < NCELLS; i++) begin
                if (i != CENTER_IX) begin
                    heat_sum = heat_sum + {{16{win[i][CELL_W-1]}}, win[i]};
                end
            end
            val        = (heat_sum >> 3) & VALUE_MASK;
            carry_next = heat_sum[CARRY_W-1:0];
        end else begin
            ones = 0;
            twos = 0;
            c    = '0;
            // cells less the flow, wrapped to 16 bits
            for (int i = 0; i < NCELLS; i++) begin
                v    = win[i] - flow32[CELL_W-1:0];
                ones = ones + v[0];
                if (i != CENTER_IX) begin
                    twos = twos + v[1];
                end else begin
                    c = v;
                end
            end
            if (ones > ONES_HI || ones == ONES_EQ) begin
                hist = ((c << 1) & {6'd0, HIST_MASK}) | 16'd1;
                if (c[2:1] == 2'b00 && twos == TWOS_BIRTH) begin
                    hist = hist | 16'd2;
                end
            end else begin
                hist = ((c ^ 16'd2) << 1) & {6'd0, HIST_MASK};
                if (c[1]) begin
                    if (twos != TWOS_FIVE) begin
                        hist = hist | 16'd2;
                    end
                end else if (twos != TWOS_FIVE && twos != TWOS_SIX) begin
                    hist = hist | 16'd2;
                end
            end
            val = (flow32 + {16'd0, hist}) & VALUE_MASK;
        end
        return {carry_next, val[CELL_W-1:0] | flag_q};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rule_q  = RULE_HEAT;
            flow_q  = FLOW_RESET;
            flag_q  = FLAG_RESET;
            carry_q = '0;
            expected_cells.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RULE_SELECT:  rule_q = i_cfg_data[0];
                    CFG_FLOW_OFFSET:  flow_q = i_cfg_data[FLOW_W-1:0];
                    CFG_FLAG_PATTERN: flag_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_cells.size() == 0) begin
                    $error("new_cell: unexpected item, got %h", i_new_cell);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    wanted = expected_cells.pop_front();
                    if (i_new_cell !== wanted) begin
                        $error("new_cell mismatch: expected %h, got %h", wanted, i_new_cell);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predicted = predict_cell(i_window, carry_q);
                carry_q   = predicted[CARRY_W+CELL_W-1:CELL_W];
                expected_cells.push_back(predicted[CELL_W-1:0]);
            end
        end
        o_pending = expected_cells.size();
    end

endmodule

@@ tb/cellular_automaton_cell_update_tb.sv @@
// ----------------------------------------------------------------------------
// cellular_automaton_cell_update_tb
// Drives 3x3 windows and config writes into the cell update block: a directed
// pass over field extremes and both rules' special cases, then random phases
// under varied sender gaps and receiver stalls. The checker does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cellular_automaton_cell_update_tb;

    import cacu_pkg::*;

    localparam int VALUE_BITS   = 10;
    localparam int CLK_PERIOD   = 10;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 16;
    localparam int PHASE_ITEMS  = 120;
    localparam logic [1:0] CFG_SPARE = 2'd3;   // no register behind it

    typedef logic [0:NCELLS-1][CELL_W-1:0] t_window;

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          cfg_we    = 1'b0;
    logic [1:0]    cfg_index = '0;
    logic [15:0]   cfg_data  = '0;
    logic          in_valid  = 1'b0;
    wire           in_stall;
    t_window       cells_q   = '0;
    wire           out_valid;
    logic          out_stall = 1'b0;
    wire  [15:0]   new_cell;

    int            fail_count;
    int            pending;
    int            cycle_count   = 0;
    int            idle_pct      = 0;
    int            stall_pct     = 0;
    int            hold_requests = 0;
    int            hold_seen     = 0;
    int            hold_left     = 0;

    cellular_automaton_cell_update #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_valid      (in_valid),
        .o_stall      (in_stall),
        .i_north_west (cells_q[0]),
        .i_north      (cells_q[1]),
        .i_north_east (cells_q[2]),
        .i_west       (cells_q[3]),
        .i_center     (cells_q[4]),
        .i_east       (cells_q[5]),
        .i_south_west (cells_q[6]),
        .i_south      (cells_q[7]),
        .i_south_east (cells_q[8]),
        .o_valid      (out_valid),
        .i_stall      (out_stall),
        .o_new_cell   (new_cell)
    );

    cellular_automaton_cell_update_checker #(
        .VALUE_BITS (VALUE_BITS)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_window     (cells_q),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_new_cell   (new_cell),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("cellular_automaton_cell_update_tb: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send_window(input t_window win);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cells_q  <= win;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic t_window random_window();
        t_window win;
        int      style;
        style = $urandom_range(0, 9);
        for (int i = 0; i < NCELLS; i++) begin
            case (style)
                0: begin
                    case ($urandom_range(0, 3))
                        0: win[i] = 16'h7fff;
                        1: win[i] = 16'h8000;
                        2: win[i] = 16'h0000;
                        default: win[i] = 16'hffff;
                    endcase
                end
                1: win[i] = 16'($urandom_range(0, 15));
                default: win[i] = 16'($urandom());
            endcase
        end
        return win;
    endfunction

    initial begin
        logic [15:0] data;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // heat rule at reset settings: field extremes
        send_window({NCELLS{16'h0000}});
        send_window({NCELLS{16'h7fff}});
        send_window({NCELLS{16'h8000}});
        send_window({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                     16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        send_window({NCELLS{16'hffff}});
        drain();
        write_reg(CFG_FLOW_OFFSET, 16'h01ff);
        write_reg(CFG_FLAG_PATTERN, 16'h0000);
        send_window({NCELLS{16'h7fff}});
        drain();
        write_reg(CFG_FLOW_OFFSET, 16'h0200);
        write_reg(CFG_FLAG_PATTERN, 16'hffff);
        send_window({NCELLS{16'h8000}});
        drain();

        // eco rule with zero flow so the counts are easy to place
        write_reg(CFG_RULE_SELECT, {15'd0, RULE_ECO});
        write_reg(CFG_FLOW_OFFSET, 16'h0000);
        write_reg(CFG_FLAG_PATTERN, 16'h0000);
        send_window({NCELLS{16'h0001}});                   // many ones
        send_window({{4{16'h0001}}, {5{16'h0000}}});       // exactly four ones
        // four ones, quiet center, two neighbors with bit 1: birth
        send_window({{4{16'h0001}}, 16'h0000, 16'h0002, 16'h0002, 16'h0000,
                     16'h0000});
        // center bit 1 set, five neighbors with bit 1
        send_window({{4{16'h0002}}, 16'h0002, 16'h0002, {3{16'h0000}}});
        // center bit 1 clear, six and then five neighbors with bit 1
        send_window({{4{16'h0002}}, 16'h0000, {2{16'h0002}}, {2{16'h0000}}});
        send_window({{4{16'h0002}}, 16'h0000, 16'h0002, {3{16'h0000}}});
        send_window({{4{16'h0001}}, 16'h0001, {4{16'h0000}}});
        drain();
        // cells less flow wrap past 16 bits
        write_reg(CFG_FLOW_OFFSET, 16'h0200);
        send_window({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'hffff,
                     16'h0000, 16'h8000, 16'h7fff, 16'hfe00});
        drain();
        write_reg(CFG_FLOW_OFFSET, 16'h01ff);
        send_window({16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h8000,
                     16'h01ff, 16'h0200, 16'h7fff, 16'h8000});
        drain();
        // back to heat: carry kept from before the eco items
        write_reg(CFG_SPARE, 16'($urandom()));
        write_reg(CFG_RULE_SELECT, 16'hfffe);
        send_window({NCELLS{16'h0001}});
        send_window(random_window());
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            data    = 16'($urandom());
            data[0] = phase[2] ^ phase[0];
            write_reg(CFG_RULE_SELECT, data);
            data = 16'($urandom());
            case (phase % 5)
                0: data[FLOW_W-1:0] = 10'h200;
                1: data[FLOW_W-1:0] = 10'h1ff;
                2: data[FLOW_W-1:0] = 10'h000;
                default: ;
            endcase
            write_reg(CFG_FLOW_OFFSET, data);
            case (phase % 3)
                0: write_reg(CFG_FLAG_PATTERN, 16'h0000);
                1: write_reg(CFG_FLAG_PATTERN, 16'hffff);
                default: write_reg(CFG_FLAG_PATTERN, 16'($urandom()));
            endcase
            if (phase == 5) begin
                write_reg(CFG_SPARE, 16'($urandom()));
            end

            case (phase % 4)
                0: begin idle_pct <= 0;  stall_pct <= 0;  end
                1: begin idle_pct <= 85; stall_pct <= 0;  end
                2: begin idle_pct <= 0;  stall_pct <= 85; end
                default: begin idle_pct <= 30; stall_pct <= 30; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // long receiver hold-off while items keep coming
                if (phase == 0 && n == 20) begin
                    hold_requests <= hold_requests + 1;
                end
                // sender waits for every result before going on
                if (phase == 1 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                send_window(random_window());
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("cellular_automaton_cell_update_tb: done, clean");
        end else begin
            $display("cellular_automaton_cell_update_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ cellular_automaton_cell_update.f @@
+incdir+design
design/cacu_pkg.sv
design/cacu_eco.sv
design/cellular_automaton_cell_update.sv
tb/cellular_automaton_cell_update_checker.sv
tb/cellular_automaton_cell_update_tb.sv
